// File: design/hi_lo_multiply_divide_unit_defines.svh
// assertion macros for the hi/lo multiply/divide unit
`ifndef HI_LO_MULTIPLY_DIVIDE_UNIT_DEFINES_SVH
`define HI_LO_MULTIPLY_DIVIDE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define HLMDU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hlmdu same-cycle check failed");

// next-cycle implication, sampled on clk, off while in reset
`define HLMDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hlmdu next-cycle check failed");

`endif

// File: design/hlmdu_pkg.sv
package hlmdu_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int CNT_W   = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  typedef enum logic [OP_W-1:0] {
    OP_MULT     = 3'd0,
    OP_MULT_UNS = 3'd1,
    OP_DIV      = 3'd2,
    OP_DIVU     = 3'd3,
    OP_MFHI     = 3'd4,
    OP_MFLO     = 3'd5,
    OP_MTHI     = 3'd6,
    OP_MTLO     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } state_t;

endpackage

// File: design/hlmdu_in_if.sv
interface hlmdu_in_if import hlmdu_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DATA_W-1:0] operand_a;
  logic [DATA_W-1:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

// File: design/hlmdu_out_if.sv
interface hlmdu_out_if import hlmdu_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_value;

  modport source (output valid, output read_value, input ready);
  modport sink   (input valid, input read_value, output ready);
endinterface

// File: design/hi_lo_multiply_divide_unit.sv
// HI/LO multiply/divide unit. mult, multu, div and divu run on a bit-serial
// datapath that works on operand magnitudes: the input transaction loads the
// working registers (HI:LO double as the shift register), shift-add or
// restoring shift-subtract steps follow, one bit per cycle, and a last
// step applies the signs, so such an operation occupies the unit through
// the serial run and the sign fix, and no transaction is taken meanwhile.
// mthi, mtlo, mfhi and mflo are done when taken; mfhi and mflo load the
// output register, and while a result waits there on a stalled receiver no
// transaction is taken. A zero divisor leaves the dividend in HI and all
// ones in LO (1 for a negative signed dividend).
`include "hi_lo_multiply_divide_unit_defines.svh"

module hi_lo_multiply_divide_unit import hlmdu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  hlmdu_in_if.sink    in_ch,
  hlmdu_out_if.source out_ch
);

  state_t              state_r, state_nxt;
  logic [DATA_W-1:0]   hi_r, hi_nxt;
  logic [DATA_W-1:0]   lo_r, lo_nxt;
  logic [DATA_W-1:0]   opnd_r, opnd_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                is_div_r, is_div_nxt;
  logic                neg_hi_r, neg_hi_nxt;
  logic                neg_lo_r, neg_lo_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;

  op_t                 op;
  logic                in_fire;
  logic                is_arith;
  logic                is_read;
  logic                is_signed;
  logic                a_neg, b_neg;
  logic [DATA_W-1:0]   a_mag, b_mag;
  logic                in_ready;
  logic                do_start, do_step, do_fix;
  logic [DATA_W:0]     mul_sum;
  logic [DATA_W:0]     div_shift;
  logic                div_ge;
  logic [DATA_W:0]     div_diff;
  logic [2*DATA_W-1:0] prod_neg;

  assign op        = op_t'(in_ch.opcode);
  assign in_fire   = in_ch.valid && in_ready;
  assign is_arith  = (op == OP_MULT) || (op == OP_MULT_UNS) || (op == OP_DIV) ||
                     (op == OP_DIVU);
  assign is_read   = (op == OP_MFHI) || (op == OP_MFLO);
  assign is_signed = (op == OP_MULT) || (op == OP_DIV);
  assign a_neg     = is_signed && in_ch.operand_a[DATA_W-1];
  assign b_neg     = is_signed && in_ch.operand_b[DATA_W-1];
  assign a_mag     = a_neg ? (~in_ch.operand_a + DATA_W'(1)) : in_ch.operand_a;
  assign b_mag     = b_neg ? (~in_ch.operand_b + DATA_W'(1)) : in_ch.operand_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (do_start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    do_step  = 1'b0;
    do_fix   = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = !out_valid_r || out_ch.ready;
      ST_RUN:  do_step  = 1'b1;
      ST_FIX:  do_fix   = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign do_start = in_fire && is_arith;

  // one multiply bit: add multiplicand when the low multiplier bit is set
  assign mul_sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, opnd_r} : '0);
  // one divide bit: shift the next dividend bit into the partial remainder
  assign div_shift = {hi_r, lo_r[DATA_W-1]};
  assign div_ge    = div_shift >= {1'b0, opnd_r};
  assign div_diff  = div_shift - {1'b0, opnd_r};
  assign prod_neg  = ~{hi_r, lo_r} + (2*DATA_W)'(1);

  always_comb begin
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    opnd_nxt      = opnd_r;
    cnt_nxt       = cnt_r;
    is_div_nxt    = is_div_r;
    neg_hi_nxt    = neg_hi_r;
    neg_lo_nxt    = neg_lo_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      unique case (op)
        OP_MULT, OP_MULT_UNS: begin
          hi_nxt     = '0;
          lo_nxt     = b_mag;
          opnd_nxt   = a_mag;
          is_div_nxt = 1'b0;
          neg_hi_nxt = 1'b0;
          neg_lo_nxt = a_neg ^ b_neg;
        end
        OP_DIV, OP_DIVU: begin
          hi_nxt     = '0;
          lo_nxt     = a_mag;
          opnd_nxt   = b_mag;
          is_div_nxt = 1'b1;
          neg_hi_nxt = a_neg;
          neg_lo_nxt = a_neg ^ b_neg;
        end
        OP_MFHI: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = hi_r;
        end
        OP_MFLO: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = lo_r;
        end
        OP_MTHI: hi_nxt = in_ch.operand_a;
        OP_MTLO: lo_nxt = in_ch.operand_a;
        default: hi_nxt = hi_r;
      endcase
      cnt_nxt = '0;
    end

    if (do_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (is_div_r) begin
        hi_nxt = div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
        lo_nxt = {lo_r[DATA_W-2:0], div_ge};
      end else begin
        hi_nxt = mul_sum[DATA_W:1];
        lo_nxt = {mul_sum[0], lo_r[DATA_W-1:1]};
      end
    end

    if (do_fix) begin
      if (is_div_r) begin
        hi_nxt = neg_hi_r ? (~hi_r + DATA_W'(1)) : hi_r;
        lo_nxt = neg_lo_r ? (~lo_r + DATA_W'(1)) : lo_r;
      end else if (neg_lo_r) begin
        hi_nxt = prod_neg[2*DATA_W-1:DATA_W];
        lo_nxt = prod_neg[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hi_r        <= '0;
      lo_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opnd_r     <= opnd_nxt;
    is_div_r   <= is_div_nxt;
    neg_hi_r   <= neg_hi_nxt;
    neg_lo_r   <= neg_lo_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_data_r;

  // a multiply or divide transaction starts the serial run
  `HLMDU_ASSERT_NEXT(a_start_runs, do_start, state_r == ST_RUN && cnt_r == '0)
  // the run ends after the last bit and goes to the sign fix
  `HLMDU_ASSERT_NEXT(a_run_ends, state_r == ST_RUN && cnt_r == CNT_LAST, state_r == ST_FIX)
  // a move-from transaction always leaves a result waiting
  `HLMDU_ASSERT_NEXT(a_read_result, in_fire && is_read, out_valid_r)
  // no transaction is taken while the serial datapath is busy
  `HLMDU_ASSERT_SAME(a_busy_blocks, state_r != ST_IDLE, !in_ready)

endmodule

// File: verif/hi_lo_multiply_divide_unit_tb.sv
module hi_lo_multiply_divide_unit_tb import hlmdu_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam int RANDOM_PER_PHASE = 435;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  // shadow copy of HI/LO and the mfhi/mflo values still owed by the block
  class hilo_shadow;
    logic [DATA_W-1:0] hi_word;
    logic [DATA_W-1:0] lo_word;
    logic [DATA_W-1:0] expected_reads[$];
    int mismatches;

    function new();
      hi_word = '0;
      lo_word = '0;
      mismatches = 0;
    endfunction

    function void accept_op(op_t op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] num_mag;
      logic [DATA_W-1:0] den_mag;
      logic [DATA_W-1:0] quo;
      logic [DATA_W-1:0] rem;
      case (op)
        OP_MULT: begin
          // low 64 bits of the product of sign-extended operands
          {hi_word, lo_word} = {{DATA_W{a[DATA_W-1]}}, a} * {{DATA_W{b[DATA_W-1]}}, b};
        end
        OP_MULT_UNS: begin
          {hi_word, lo_word} = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
        end
        OP_DIV: begin
          if (b == '0) begin
            hi_word = a;
            lo_word = a[DATA_W-1] ? 32'd1 : ALL_ONES;
          end else if (a == MOST_NEG && b == ALL_ONES) begin
            hi_word = '0;
            lo_word = MOST_NEG;
          end else begin
            num_mag = a[DATA_W-1] ? 32'd0 - a : a;
            den_mag = b[DATA_W-1] ? 32'd0 - b : b;
            quo = num_mag / den_mag;
            rem = num_mag % den_mag;
            lo_word = (a[DATA_W-1] ^ b[DATA_W-1]) ? 32'd0 - quo : quo;
            hi_word = a[DATA_W-1] ? 32'd0 - rem : rem;
          end
        end
        OP_DIVU: begin
          if (b == '0) begin
            hi_word = a;
            lo_word = ALL_ONES;
          end else begin
            hi_word = a % b;
            lo_word = a / b;
          end
        end
        OP_MFHI: expected_reads.push_back(hi_word);
        OP_MFLO: expected_reads.push_back(lo_word);
        OP_MTHI: hi_word = a;
        OP_MTLO: lo_word = a;
        default: ;
      endcase
    endfunction

    function void check_read(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (expected_reads.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected read transaction: got %08h", got);
        mismatches++;
        return;
      end
      want = expected_reads.pop_front();
      if (got !== want) begin
        if (mismatches < MAX_REPORTS)
          $display("read_value mismatch: expected %08h, got %08h", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hlmdu_in_if  in_ch();
  hlmdu_out_if out_ch();

  hi_lo_multiply_divide_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hilo_shadow tracker = new();

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_op(op_t op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    tracker.accept_op(op, a, b);
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(15))
      0: return '0;
      1: return 32'd1;
      2: return ALL_ONES;
      3: return MOST_NEG;
      4: return ~MOST_NEG;
      5: return 32'($urandom_range(15));
      6: return 32'd0 - 32'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 35) return op_t'($urandom_range(OP_MULT, OP_DIVU));
    if (r < 50) return op_t'($urandom_range(OP_MTHI, OP_MTLO));
    return op_t'($urandom_range(OP_MFHI, OP_MFLO));
  endfunction

  task automatic send_random_op();
    if ($urandom_range(99) < 3)
      send_op(OP_DIV, MOST_NEG, ALL_ONES);
    else
      send_op(pick_op(), pick_operand(), pick_operand());
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_read(out_ch.read_value);
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int send_idle_by_phase[4];
    int stall_by_phase[4];
    send_idle_by_phase = '{0, 66, 0, 11};
    stall_by_phase     = '{0, 0, 66, 11};
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_MFHI;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, moves, sign handling and divide corner cases
    send_op(OP_MFHI, $urandom(), $urandom());
    send_op(OP_MFLO, ALL_ONES, ALL_ONES);
    send_op(OP_MTHI, ALL_ONES, ALL_ONES);
    send_op(OP_MTLO, '0, $urandom());
    send_op(OP_MFHI, '0, '0);
    send_op(OP_MFLO, '0, '0);
    send_op(OP_MULT, ALL_ONES, 32'd2);
    send_op(OP_MFHI, '0, '0);
    send_op(OP_MFLO, '0, '0);
    send_op(OP_MULT_UNS, ALL_ONES, ALL_ONES);
    send_op(OP_MFHI, '0, '0);
    send_op(OP_MFLO, '0, '0);
    send_op(OP_DIV, MOST_NEG, ALL_ONES);
    send_op(OP_MFHI, '0, '0);
    send_op(OP_MFLO, '0, '0);
    send_op(OP_DIV, 32'h8000_0007, '0);
    send_op(OP_MFLO, '0, '0);
    send_op(OP_MFHI, '0, '0);
    send_op(OP_DIVU, 32'h0001_2345, '0);
    send_op(OP_MFLO, '0, '0);
    send_op(OP_DIV, 32'hffff_fff9, 32'd2);
    send_op(OP_MFHI, '0, '0);
    send_op(OP_MFLO, '0, '0);
    send_op(OP_DIVU, ALL_ONES, 32'd10);
    send_op(OP_MFHI, '0, '0);

    // long receiver hold-off while reads keep coming, so the input backs up
    hold_requests <= hold_requests + 1;
    repeat (16) send_op(op_t'($urandom_range(OP_MFHI, OP_MTHI)), $urandom(), $urandom());

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_by_phase[ph];
      stall_pct <= stall_by_phase[ph];
      repeat (RANDOM_PER_PHASE) send_random_op();
    end

    in_ch.valid <= 1'b0;
    stall_pct <= 0;
    while (tracker.expected_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.expected_reads.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
